// ===== sv/temporal_tv_gradient_update_assert.svh =====
// assertion macros for the temporal tv gradient block
`ifndef TEMPORAL_TV_GRADIENT_UPDATE_ASSERT_SVH
`define TEMPORAL_TV_GRADIENT_UPDATE_ASSERT_SVH

// same-cycle implication
`define TTVG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTVG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ttvg_pkg.sv =====
// shared types and constants for the temporal tv gradient block
package ttvg_pkg;

  localparam int DATA_W      = 32;
  localparam int MAG_W       = 32;
  localparam int SQ_W        = 64;
  localparam int RAD_W       = 66;
  localparam int ROOT_W      = 33;
  localparam int TRIAL_W     = RAD_W + 1;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int NUM_W       = 48;
  localparam int DIV_W       = 50;
  localparam int DIV_STAGES  = 17;
  localparam int Q_W         = 18;
  localparam int SIDE_LEN    = SQRT_STAGES + DIV_STAGES;
  localparam int LATENCY     = 3 + SIDE_LEN + 5;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_SQ = 1'b1;
  localparam logic [DATA_W-1:0] CFG_RESET = 32'h0001_0000;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] cur_real;
    logic signed [DATA_W-1:0] cur_imag;
    logic signed [DATA_W-1:0] next_real;
    logic signed [DATA_W-1:0] next_imag;
    logic signed [DATA_W-1:0] prev_real;
    logic signed [DATA_W-1:0] prev_imag;
    logic        [DATA_W-1:0] pixel_weight;
    logic signed [DATA_W-1:0] grad_real_in;
    logic signed [DATA_W-1:0] grad_imag_in;
  } ttvg_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] grad_real_out;
    logic signed [DATA_W-1:0] grad_imag_out;
    logic                     clipped;
  } ttvg_out_t;

endpackage

// ===== sv/temporal_tv_gradient_update.sv =====
// top level of the temporal total-variation gradient update pipeline
//
// one complex pixel per item: start with in_data accepted whenever busy is
// low; busy never rises, so an item may be issued in every cycle.
// each item yields exactly one result: out_valid strobes for one cycle with
// out_data, both driven from registers at the end of the pipeline.
// throughput is one item per clock; the pipeline is 58 register stages:
// differences, squares, radicand, 33 square-root stages (one root bit each),
// 17 divider stages (one quotient bit each), then the difference of the
// normalised terms, two multiply stages, a sum and the saturating add.
// the configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 writes beta, index 1 writes beta_sq. write it
// only while no item is in flight.
// reset (rst_n low, synchronous) empties the pipeline and sets both
// registers to 1.0; items in flight are dropped.
// the receiver cannot stall: results are never held back.
`include "temporal_tv_gradient_update_assert.svh"

module temporal_tv_gradient_update (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  ttvg_pkg::ttvg_in_t                     in_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ttvg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ttvg_pkg::DATA_W-1:0]            cfg_data,
  output logic                                   out_valid,
  output ttvg_pkg::ttvg_out_t                    out_data
);
  import ttvg_pkg::*;

  typedef struct packed {
    logic [3:0][MAG_W-1:0]    mag;
    logic [3:0]               neg;
    logic [DATA_W-1:0]        w;
    logic signed [DATA_W-1:0] gr;
    logic signed [DATA_W-1:0] gi;
  } side_t;

  typedef struct packed {
    logic [DATA_W-1:0]        w;
    logic signed [DATA_W-1:0] gr;
    logic signed [DATA_W-1:0] gi;
  } tail_t;

  logic              accept;
  logic [DATA_W-1:0] beta_r;
  logic [DATA_W-1:0] beta_sq_r;
  logic              vld_r [0:LATENCY-1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r    <= CFG_RESET;
      beta_sq_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BETA:    beta_r    <= cfg_data;
        CFG_BETA_SQ: beta_sq_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LATENCY; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < LATENCY; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // stage 0: differences and magnitudes
  logic signed [DATA_W:0] diff [0:3];
  logic [DATA_W:0]        dabs [0:3];
  side_t                  s0_nxt;
  side_t                  s0_r;

  always_comb begin
    diff[0] = {in_data.cur_real[DATA_W-1], in_data.cur_real}
            - {in_data.next_real[DATA_W-1], in_data.next_real};
    diff[1] = {in_data.cur_imag[DATA_W-1], in_data.cur_imag}
            - {in_data.next_imag[DATA_W-1], in_data.next_imag};
    diff[2] = {in_data.prev_real[DATA_W-1], in_data.prev_real}
            - {in_data.cur_real[DATA_W-1], in_data.cur_real};
    diff[3] = {in_data.prev_imag[DATA_W-1], in_data.prev_imag}
            - {in_data.cur_imag[DATA_W-1], in_data.cur_imag};
    for (int i = 0; i < 4; i++) begin
      dabs[i]       = diff[i][DATA_W] ? -diff[i] : diff[i];
      s0_nxt.mag[i] = dabs[i][MAG_W-1:0];
      s0_nxt.neg[i] = diff[i][DATA_W];
    end
    s0_nxt.w  = in_data.pixel_weight;
    s0_nxt.gr = in_data.grad_real_in;
    s0_nxt.gi = in_data.grad_imag_in;
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
  end

  // stage 1: squares
  logic [SQ_W-1:0] sq_r [0:3];
  side_t           s1_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) sq_r[i] <= s0_r.mag[i] * s0_r.mag[i];
    s1_r <= s0_r;
  end

  // stage 2: radicands
  logic [RAD_W-1:0] bsq_ext;
  logic [RAD_W-1:0] rad_r [0:1];
  side_t            s2_r;

  assign bsq_ext = {{(RAD_W-DATA_W-16){1'b0}}, beta_sq_r, 16'h0000};

  always_ff @(posedge clk) begin
    rad_r[0] <= {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + bsq_ext;
    rad_r[1] <= {2'b00, sq_r[2]} + {2'b00, sq_r[3]} + bsq_ext;
    s2_r     <= s1_r;
  end

  // side data alongside the root and divide pipelines
  side_t side_r [0:SIDE_LEN-1];

  always_ff @(posedge clk) begin
    side_r[0] <= s2_r;
    for (int i = 1; i < SIDE_LEN; i++) side_r[i] <= side_r[i-1];
  end

  logic [ROOT_W-1:0]     root [0:1];
  logic signed [Q_W-1:0] quo  [0:3];

  genvar g;
  for (g = 0; g < 2; g++) begin : g_root
    ttvg_sqrt u_sqrt (
      .clk  (clk),
      .rad  (rad_r[g]),
      .root (root[g])
    );
  end

  for (g = 0; g < 4; g++) begin : g_div
    ttvg_div u_div (
      .clk     (clk),
      .num_mag (side_r[SQRT_STAGES-1].mag[g]),
      .num_neg (side_r[SQRT_STAGES-1].neg[g]),
      .den     (root[g/2]),
      .quo     (quo[g])
    );
  end

  // difference of normalised terms
  logic signed [Q_W:0] dn   [0:1];
  logic [Q_W:0]        dnab [0:1];
  logic [Q_W-1:0]      nmag_r [0:1];
  logic                nneg_r [0:1];
  tail_t               tn_r;

  always_comb begin
    dn[0]   = {quo[0][Q_W-1], quo[0]} - {quo[2][Q_W-1], quo[2]};
    dn[1]   = {quo[1][Q_W-1], quo[1]} - {quo[3][Q_W-1], quo[3]};
    dnab[0] = dn[0][Q_W] ? -dn[0] : dn[0];
    dnab[1] = dn[1][Q_W] ? -dn[1] : dn[1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      nmag_r[i] <= dnab[i][Q_W-1:0];
      nneg_r[i] <= dn[i][Q_W];
    end
    tn_r.w  <= side_r[SIDE_LEN-1].w;
    tn_r.gr <= side_r[SIDE_LEN-1].gr;
    tn_r.gi <= side_r[SIDE_LEN-1].gi;
  end

  // multiply by beta
  localparam int P1_W = Q_W + DATA_W;
  localparam int PH_W = P1_W - DATA_W + DATA_W;
  logic [P1_W-1:0]   p1_r  [0:1];
  logic              neg1_r [0:1];
  tail_t             t1_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      p1_r[i]   <= nmag_r[i] * beta_r;
      neg1_r[i] <= nneg_r[i];
    end
    t1_r <= tn_r;
  end

  // multiply by weight, split into two partial products
  logic [2*DATA_W-1:0] pl_r  [0:1];
  logic [PH_W-1:0]     ph_r  [0:1];
  logic                neg2_r [0:1];
  tail_t               t2_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      pl_r[i]   <= p1_r[i][DATA_W-1:0] * t1_r.w;
      ph_r[i]   <= p1_r[i][P1_W-1:DATA_W] * t1_r.w;
      neg2_r[i] <= neg1_r[i];
    end
    t2_r <= t1_r;
  end

  // recombine and apply sign
  localparam int T_W    = PH_W + 1;
  localparam int TERM_W = T_W + 1;
  logic [T_W-1:0]           tmag  [0:1];
  logic signed [TERM_W-1:0] term_r [0:1];
  tail_t                    t3_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      tmag[i] = {1'b0, ph_r[i]} + {{(T_W-DATA_W){1'b0}}, pl_r[i][2*DATA_W-1:DATA_W]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      term_r[i] <= neg2_r[i] ? -$signed({1'b0, tmag[i]}) : $signed({1'b0, tmag[i]});
    end
    t3_r <= t2_r;
  end

  // add incoming gradient and saturate
  localparam int SUM_W = TERM_W + 1;
  logic signed [SUM_W-1:0]  sum  [0:1];
  logic signed [DATA_W-1:0] satv [0:1];
  logic [1:0]               ovf;
  ttvg_out_t                out_nxt;
  ttvg_out_t                out_r;

  always_comb begin
    sum[0] = {{(SUM_W-DATA_W){t3_r.gr[DATA_W-1]}}, t3_r.gr}
           + {term_r[0][TERM_W-1], term_r[0]};
    sum[1] = {{(SUM_W-DATA_W){t3_r.gi[DATA_W-1]}}, t3_r.gi}
           + {term_r[1][TERM_W-1], term_r[1]};
    for (int i = 0; i < 2; i++) begin
      ovf[i] = (sum[i][SUM_W-1:DATA_W-1] != '0) && (sum[i][SUM_W-1:DATA_W-1] != '1);
      if (!ovf[i]) begin
        satv[i] = sum[i][DATA_W-1:0];
      end else if (sum[i][SUM_W-1]) begin
        satv[i] = SAT_MIN;
      end else begin
        satv[i] = SAT_MAX;
      end
    end
    out_nxt.grad_real_out = satv[0];
    out_nxt.grad_imag_out = satv[1];
    out_nxt.clipped       = |ovf;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[LATENCY-1];
  assign out_data  = out_r;

  `TTVG_ASSERT_IMP(a_out_has_item, clk, rst_n, out_valid, $past(accept, LATENCY),
    "result strobe without an item accepted at the pipeline depth")
  `TTVG_ASSERT_IMP(a_clip_saturates, clk, rst_n, out_valid && out_data.clipped,
    out_data.grad_real_out == SAT_MAX || out_data.grad_real_out == SAT_MIN ||
    out_data.grad_imag_out == SAT_MAX || out_data.grad_imag_out == SAT_MIN,
    "clipped set without a saturated part")
  `TTVG_ASSERT_NXT(a_cfg_beta, clk, rst_n,
    cfg_valid && cfg_ready && cfg_index == CFG_BETA, beta_r == $past(cfg_data),
    "beta write not taken")
  `TTVG_ASSERT_NXT(a_cfg_beta_sq, clk, rst_n,
    cfg_valid && cfg_ready && cfg_index == CFG_BETA_SQ, beta_sq_r == $past(cfg_data),
    "beta_sq write not taken")

endmodule

// ===== sv/ttvg_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module ttvg_sqrt (
  input  logic                         clk,
  input  logic [ttvg_pkg::RAD_W-1:0]   rad,
  output logic [ttvg_pkg::ROOT_W-1:0]  root
);
  import ttvg_pkg::*;

  logic [RAD_W-1:0]  rem_r  [0:SQRT_STAGES-1];
  logic [ROOT_W-1:0] root_r [0:SQRT_STAGES-1];

  genvar k;
  for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic [TRIAL_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign trial = ({{(TRIAL_W-ROOT_W){1'b0}}, root_in} << (B + 1))
                 + (TRIAL_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if ({1'b0, rem_in} >= trial) begin
        rem_r[k]  <= rem_in - trial[RAD_W-1:0];
        root_r[k] <= root_in | (ROOT_W'(1) << B);
      end else begin
        rem_r[k]  <= rem_in;
        root_r[k] <= root_in;
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

// ===== sv/ttvg_div.sv =====
// pipelined restoring divider for the normalised difference, one quotient bit per stage
module ttvg_div (
  input  logic                              clk,
  input  logic [ttvg_pkg::MAG_W-1:0]        num_mag,
  input  logic                              num_neg,
  input  logic [ttvg_pkg::ROOT_W-1:0]       den,
  output logic signed [ttvg_pkg::Q_W-1:0]   quo
);
  import ttvg_pkg::*;

  logic [NUM_W-1:0]      rem_r [0:DIV_STAGES-1];
  logic [ROOT_W-1:0]     den_r [0:DIV_STAGES-1];
  logic [DIV_STAGES-1:0] quo_r [0:DIV_STAGES-1];
  logic                  neg_r [0:DIV_STAGES-1];

  genvar k;
  for (k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int B = DIV_STAGES - 1 - k;
    logic [NUM_W-1:0]      rem_in;
    logic [ROOT_W-1:0]     den_in;
    logic [DIV_STAGES-1:0] quo_in;
    logic                  neg_in;
    logic [DIV_W-1:0]      trial;

    if (k == 0) begin : g_first
      assign rem_in = {num_mag, {(NUM_W-MAG_W){1'b0}}};
      assign den_in = den;
      assign quo_in = '0;
      assign neg_in = num_neg;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign neg_in = neg_r[k-1];
    end

    assign trial = {{(DIV_W-ROOT_W){1'b0}}, den_in} << B;

    always_ff @(posedge clk) begin
      den_r[k] <= den_in;
      neg_r[k] <= neg_in;
      if ({{(DIV_W-NUM_W){1'b0}}, rem_in} >= trial) begin
        rem_r[k] <= rem_in - trial[NUM_W-1:0];
        quo_r[k] <= quo_in | (DIV_STAGES'(1) << B);
      end else begin
        rem_r[k] <= rem_in;
        quo_r[k] <= quo_in;
      end
    end
  end

  logic [Q_W-1:0] q_mag;
  assign q_mag = {{(Q_W-DIV_STAGES){1'b0}}, quo_r[DIV_STAGES-1]};

  always_comb begin
    if (den_r[DIV_STAGES-1] == '0) begin
      quo = '0;
    end else if (neg_r[DIV_STAGES-1]) begin
      quo = -$signed(q_mag);
    end else begin
      quo = $signed(q_mag);
    end
  end

endmodule
